// ===== rtl/core/atsl_pkg.sv =====
`timescale 1ns / 1ps

package atsl_pkg;

   // Table sizes and offset width
   localparam int MAX_SECTIONS = 16;
   localparam int MAX_SYMBOLS  = 256;
   localparam int ADDR_WIDTH   = 32;

   localparam int SEC_IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int SEC_NUM_W = $clog2(MAX_SECTIONS + 1);
   localparam int SYM_IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
   localparam int SYM_NUM_W = $clog2(MAX_SYMBOLS + 1);

   // Fixed field widths of the channels and count registers
   localparam int OPCODE_W      = 2;
   localparam int ENTRY_IDX_W   = 8;
   localparam int SEC_FIELD_W   = 5;
   localparam int WORD_W        = 32;
   localparam int SEC_COUNT_W   = 5;
   localparam int SYM_COUNT_W   = 9;

   // Symbol RAM word: section number above the value
   localparam int SYM_ENTRY_W = SEC_FIELD_W + ADDR_WIDTH;

   // Register port
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_INDEX_BIT = 2;
   localparam logic REG_SECTION_COUNT = 1'b0;
   localparam logic REG_SYMBOL_COUNT  = 1'b1;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_LOAD_SECTION = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_LOAD_SYMBOL  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY        = 2'd2;

   // Query token moving down the section chain
   typedef struct packed {
      logic                  valid;
      logic [ADDR_WIDTH-1:0] addr;
      logic [SEC_NUM_W-1:0]  sid;
      logic [ADDR_WIDTH-1:0] offset;
   } sec_tok_type;

   typedef struct packed {
      logic                   found;
      logic [SEC_FIELD_W-1:0] section_number;
      logic [ENTRY_IDX_W-1:0] symbol_index;
      logic [WORD_W-1:0]      symbol_value;
      logic [WORD_W-1:0]      distance;
   } result_type;

endpackage

// ===== rtl/core/atsl_channels.sv =====
`timescale 1ns / 1ps

interface atsl_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [atsl_pkg::OPCODE_W-1:0]        opcode;
   logic [atsl_pkg::ENTRY_IDX_W-1:0]     entry_index;
   logic [atsl_pkg::WORD_W-1:0]          section_base;
   logic [atsl_pkg::WORD_W-1:0]          section_length;
   logic [atsl_pkg::SEC_FIELD_W-1:0]     symbol_section;
   logic [atsl_pkg::WORD_W-1:0]          symbol_offset;
   logic [atsl_pkg::WORD_W-1:0]          query_address;

   modport source (
      output valid, opcode, entry_index, section_base, section_length,
             symbol_section, symbol_offset, query_address,
      input  ready
   );
   modport sink (
      input  valid, opcode, entry_index, section_base, section_length,
             symbol_section, symbol_offset, query_address,
      output ready
   );
endinterface

interface atsl_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 found;
   logic [atsl_pkg::SEC_FIELD_W-1:0]     section_number;
   logic [atsl_pkg::ENTRY_IDX_W-1:0]     symbol_index;
   logic [atsl_pkg::WORD_W-1:0]          symbol_value;
   logic [atsl_pkg::WORD_W-1:0]          distance;

   modport source (
      output valid, found, section_number, symbol_index, symbol_value, distance,
      input  ready
   );
   modport sink (
      input  valid, found, section_number, symbol_index, symbol_value, distance,
      output ready
   );
endinterface

// ===== rtl/core/atsl_ram.sv =====
`timescale 1ns / 1ps

module atsl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/atsl_sec_cell.sv =====
`timescale 1ns / 1ps

module atsl_sec_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [atsl_pkg::SEC_IDX_W-1:0]      cell_index,
   input  logic [atsl_pkg::SEC_NUM_W-1:0]      active_count,
   input  logic                                load_en,
   input  logic [atsl_pkg::SEC_IDX_W-1:0]      load_slot,
   input  logic [atsl_pkg::ADDR_WIDTH-1:0]     load_base,
   input  logic [atsl_pkg::ADDR_WIDTH-1:0]     load_length,
   input  atsl_pkg::sec_tok_type               up_tok,
   output atsl_pkg::sec_tok_type               down_tok
);

   logic [atsl_pkg::ADDR_WIDTH-1:0] base_ff;
   logic [atsl_pkg::ADDR_WIDTH-1:0] length_ff;
   logic [atsl_pkg::ADDR_WIDTH-1:0] rel;
   logic                            hit;
   atsl_pkg::sec_tok_type           tok_in;
   atsl_pkg::sec_tok_type           tok_ff;

   always_ff @(posedge clock) begin
      if (load_en && load_slot == cell_index) begin
         base_ff   <= load_base;
         length_ff <= load_length;
      end
   end

   // First matching section claims the token; later cells pass it on
   always_comb begin
      rel = up_tok.addr - base_ff;
      hit = up_tok.valid && (up_tok.sid == '0)
            && (32'(cell_index) < 32'(active_count))
            && (up_tok.addr >= base_ff) && (rel < length_ff);
      tok_in = up_tok;
      if (hit) begin
         tok_in.sid    = atsl_pkg::SEC_NUM_W'(32'(cell_index) + 1);
         tok_in.offset = rel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign down_tok = tok_ff;

endmodule

// ===== rtl/core/atsl_sym_scan.sv =====
`timescale 1ns / 1ps

module atsl_sym_scan (
   input  logic                                clock,
   input  logic                                reset,
   input  atsl_pkg::sec_tok_type               start_tok,
   input  logic [atsl_pkg::SYM_NUM_W-1:0]      active_count,
   input  logic                                load_en,
   input  logic [atsl_pkg::SYM_IDX_W-1:0]      load_slot,
   input  logic [atsl_pkg::SEC_FIELD_W-1:0]    load_section,
   input  logic [atsl_pkg::ADDR_WIDTH-1:0]     load_value,
   input  logic                                out_free,
   output logic                                done,
   output atsl_pkg::result_type                result
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type                             state_ff;
   logic [atsl_pkg::SYM_NUM_W-1:0]        cnt_ff;
   logic                                  pend_ff;
   logic [atsl_pkg::SYM_IDX_W-1:0]        pend_idx_ff;
   logic [atsl_pkg::SEC_NUM_W-1:0]        sid_ff;
   logic [atsl_pkg::ADDR_WIDTH-1:0]       offset_ff;
   logic                                  have_ff;
   logic [atsl_pkg::SYM_IDX_W-1:0]        best_idx_ff;
   logic [atsl_pkg::ADDR_WIDTH-1:0]       best_val_ff;
   logic [atsl_pkg::ADDR_WIDTH-1:0]       best_dist_ff;

   logic                                  issue;
   logic [atsl_pkg::SYM_IDX_W-1:0]        rd_addr;
   logic [atsl_pkg::SYM_ENTRY_W-1:0]      rd_data;
   logic [atsl_pkg::SEC_FIELD_W-1:0]      rd_sec;
   logic [atsl_pkg::ADDR_WIDTH-1:0]       rd_val;
   logic [atsl_pkg::ADDR_WIDTH-1:0]       cand_dist;
   logic                                  take;

   atsl_ram #(
      .WIDTH (atsl_pkg::SYM_ENTRY_W),
      .DEPTH (atsl_pkg::MAX_SYMBOLS)
   ) u_sym_ram (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (load_slot),
      .wr_data ({load_section, load_value}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      issue     = (state_ff == S_SCAN) && (cnt_ff < active_count);
      rd_addr   = cnt_ff[atsl_pkg::SYM_IDX_W-1:0];
      rd_sec    = rd_data[atsl_pkg::SYM_ENTRY_W-1 -: atsl_pkg::SEC_FIELD_W];
      rd_val    = rd_data[atsl_pkg::ADDR_WIDTH-1:0];
      cand_dist = offset_ff - rd_val;
      // Equal distance goes to the later entry
      take      = pend_ff && (32'(rd_sec) == 32'(sid_ff)) && (rd_val <= offset_ff)
                  && (!have_ff || cand_dist <= best_dist_ff);
      done      = (state_ff == S_FINISH) && out_free;

      result.found          = have_ff;
      result.section_number = atsl_pkg::SEC_FIELD_W'(sid_ff);
      result.symbol_index   = have_ff ? atsl_pkg::ENTRY_IDX_W'(best_idx_ff) : '0;
      result.symbol_value   = have_ff ? atsl_pkg::WORD_W'(best_val_ff) : '0;
      result.distance       = have_ff ? atsl_pkg::WORD_W'(best_dist_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
         have_ff  <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start_tok.valid) begin
                  sid_ff    <= start_tok.sid;
                  offset_ff <= start_tok.offset;
                  have_ff   <= 1'b0;
                  cnt_ff    <= '0;
                  pend_ff   <= 1'b0;
                  state_ff  <= (start_tok.sid == '0) ? S_FINISH : S_SCAN;
               end
            end
            S_SCAN: begin
               pend_ff     <= issue;
               pend_idx_ff <= rd_addr;
               if (issue) begin
                  cnt_ff <= cnt_ff + atsl_pkg::SYM_NUM_W'(1);
               end
               if (take) begin
                  have_ff      <= 1'b1;
                  best_idx_ff  <= pend_idx_ff;
                  best_val_ff  <= rd_val;
                  best_dist_ff <= cand_dist;
               end
               if (!issue && !pend_ff) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               // hold the result until the output register frees up
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/core/address_to_symbol_lookup.sv =====
`timescale 1ns / 1ps

// Nearest preceding symbol lookup. Load transfers (opcode 0 section, 1 symbol)
// give no result. A query transfer walks a chain of MAX_SECTIONS registered
// section cells, where the first section holding the query address claims it;
// the symbol RAM is then read one entry per cycle over the N searched symbol
// entries (symbol_count clamped to the table size). The result lands in the
// output register once the scan ends and that register is free. The block
// takes no new transfer while a query is in flight; the next one is taken once
// the result sits in the output register, even if the result has not been
// taken yet. section_count and symbol_count sit at byte addresses 0 and 4 of
// the register port and must be written by the user only while idle; the block
// itself does not enforce it.
module address_to_symbol_lookup (
   input  logic                               clock,
   input  logic                               reset,
   atsl_req_if.sink                           req_ch,
   atsl_rsp_if.source                         rsp_ch,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [atsl_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [atsl_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [atsl_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   logic [atsl_pkg::SEC_COUNT_W-1:0]   sec_count_ff;
   logic [atsl_pkg::SYM_COUNT_W-1:0]   sym_count_ff;
   logic                               busy_ff;
   logic                               busy_in;
   logic                               rsp_valid_ff;
   atsl_pkg::result_type               rsp_data_ff;

   logic                               accept;
   logic                               csr_write;
   logic [atsl_pkg::SEC_NUM_W-1:0]     nsec;
   logic [atsl_pkg::SYM_NUM_W-1:0]     nsym;
   logic                               sec_load;
   logic                               sym_load;
   logic                               out_free;
   logic                               scan_done;
   atsl_pkg::result_type               scan_result;
   atsl_pkg::sec_tok_type              chain [atsl_pkg::MAX_SECTIONS + 1];

   // Register port
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[atsl_pkg::CSR_INDEX_BIT] == atsl_pkg::REG_SECTION_COUNT)
                       ? atsl_pkg::CSR_DATA_W'(sec_count_ff)
                       : atsl_pkg::CSR_DATA_W'(sym_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_count_ff <= '0;
         sym_count_ff <= '0;
      end else if (csr_write) begin
         if (csr_paddr[atsl_pkg::CSR_INDEX_BIT] == atsl_pkg::REG_SYMBOL_COUNT) begin
            sym_count_ff <= csr_pwdata[atsl_pkg::SYM_COUNT_W-1:0];
         end else begin
            sec_count_ff <= csr_pwdata[atsl_pkg::SEC_COUNT_W-1:0];
         end
      end
   end

   // Clamp counts to the table sizes
   assign nsec = (32'(sec_count_ff) > atsl_pkg::MAX_SECTIONS)
                 ? atsl_pkg::SEC_NUM_W'(atsl_pkg::MAX_SECTIONS)
                 : atsl_pkg::SEC_NUM_W'(sec_count_ff);
   assign nsym = (32'(sym_count_ff) > atsl_pkg::MAX_SYMBOLS)
                 ? atsl_pkg::SYM_NUM_W'(atsl_pkg::MAX_SYMBOLS)
                 : atsl_pkg::SYM_NUM_W'(sym_count_ff);

   assign req_ch.ready = !busy_ff;
   assign accept       = req_ch.valid && !busy_ff;
   assign sec_load     = accept && (req_ch.opcode == atsl_pkg::OP_LOAD_SECTION)
                         && (32'(req_ch.entry_index) < atsl_pkg::MAX_SECTIONS);
   assign sym_load     = accept && (req_ch.opcode == atsl_pkg::OP_LOAD_SYMBOL)
                         && (32'(req_ch.entry_index) < atsl_pkg::MAX_SYMBOLS);

   always_comb begin
      chain[0].valid  = accept && (req_ch.opcode == atsl_pkg::OP_QUERY);
      chain[0].addr   = atsl_pkg::ADDR_WIDTH'(req_ch.query_address);
      chain[0].sid    = '0;
      chain[0].offset = '0;
   end

   for (genvar g = 0; g < atsl_pkg::MAX_SECTIONS; g++) begin : g_sec
      atsl_sec_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cell_index   (atsl_pkg::SEC_IDX_W'(g)),
         .active_count (nsec),
         .load_en      (sec_load),
         .load_slot    (atsl_pkg::SEC_IDX_W'(req_ch.entry_index)),
         .load_base    (atsl_pkg::ADDR_WIDTH'(req_ch.section_base)),
         .load_length  (atsl_pkg::ADDR_WIDTH'(req_ch.section_length)),
         .up_tok       (chain[g]),
         .down_tok     (chain[g+1])
      );
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   atsl_sym_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .start_tok    (chain[atsl_pkg::MAX_SECTIONS]),
      .active_count (nsym),
      .load_en      (sym_load),
      .load_slot    (atsl_pkg::SYM_IDX_W'(req_ch.entry_index)),
      .load_section (req_ch.symbol_section),
      .load_value   (atsl_pkg::ADDR_WIDTH'(req_ch.symbol_offset)),
      .out_free     (out_free),
      .done         (scan_done),
      .result       (scan_result)
   );

   // Busy from query transfer until its result lands in the output register
   always_comb begin
      busy_in = busy_ff;
      if (accept && req_ch.opcode == atsl_pkg::OP_QUERY) begin
         busy_in = 1'b1;
      end else if (scan_done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (scan_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (scan_done) begin
         rsp_data_ff <= scan_result;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.found          = rsp_data_ff.found;
   assign rsp_ch.section_number = rsp_data_ff.section_number;
   assign rsp_ch.symbol_index   = rsp_data_ff.symbol_index;
   assign rsp_ch.symbol_value   = rsp_data_ff.symbol_value;
   assign rsp_ch.distance       = rsp_data_ff.distance;

endmodule

// ===== tb/sv/address_to_symbol_lookup_test.sv =====
`timescale 1ns / 1ps

module address_to_symbol_lookup_test;
   import atsl_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 300;
   localparam int LONG_HOLD     = 1000;

   typedef struct packed {
      logic [OPCODE_W-1:0]    opcode;
      logic [ENTRY_IDX_W-1:0] entry_index;
      logic [WORD_W-1:0]      section_base;
      logic [WORD_W-1:0]      section_length;
      logic [SEC_FIELD_W-1:0] symbol_section;
      logic [WORD_W-1:0]      symbol_offset;
      logic [WORD_W-1:0]      query_address;
   } lookup_req_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   atsl_req_if req_if ();
   atsl_rsp_if rsp_if ();

   address_to_symbol_lookup u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predictor state, updated as transfers are accepted
   logic [WORD_W-1:0]      tbl_base    [MAX_SECTIONS];
   logic [WORD_W-1:0]      tbl_len     [MAX_SECTIONS];
   logic [SEC_FIELD_W-1:0] tbl_sym_sec [MAX_SYMBOLS];
   logic [WORD_W-1:0]      tbl_sym_val [MAX_SYMBOLS];
   logic [SEC_COUNT_W-1:0] tbl_sections;
   logic [SYM_COUNT_W-1:0] tbl_symbols;

   // Table contents as planned by the stimulus, ahead of the block
   logic [WORD_W-1:0]      plan_base       [MAX_SECTIONS];
   logic [WORD_W-1:0]      plan_len        [MAX_SECTIONS];
   bit                     plan_sec_loaded [MAX_SECTIONS];
   logic [SEC_FIELD_W-1:0] plan_sym_sec    [MAX_SYMBOLS];
   logic [WORD_W-1:0]      plan_sym_val    [MAX_SYMBOLS];
   bit                     plan_sym_loaded [MAX_SYMBOLS];

   lookup_req_type pending_reqs[$];
   result_type     lookup_expected[$];
   lookup_req_type cur_req;
   int             queued_count;
   int             accepted_count;
   int             results_seen;
   int             failures;
   bit             req_fired;
   int             req_gap;
   bit             req_no_idle;
   int             rsp_stall;
   int             rsp_hold;
   bit             rsp_no_idle;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic bit resolve_lookup(input lookup_req_type it, output result_type res);
      logic [WORD_W-1:0] offset;
      logic [WORD_W-1:0] sym_gap;
      logic [WORD_W-1:0] best_dist;
      int                nsec;
      int                nsym;
      int                sid;
      int                best;
      bit                have;
      bit                gives;
      res = '0;
      offset = '0;
      best_dist = '0;
      sid = 0;
      best = 0;
      have = 1'b0;
      gives = 1'b0;
      nsec = (tbl_sections > MAX_SECTIONS) ? MAX_SECTIONS : int'(tbl_sections);
      nsym = (tbl_symbols > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(tbl_symbols);
      case (it.opcode)
         OP_LOAD_SECTION: begin
            if (it.entry_index < MAX_SECTIONS) begin
               tbl_base[int'(it.entry_index)] = it.section_base;
               tbl_len[int'(it.entry_index)] = it.section_length;
            end
         end
         OP_LOAD_SYMBOL: begin
            tbl_sym_sec[int'(it.entry_index)] = it.symbol_section;
            tbl_sym_val[int'(it.entry_index)] = it.symbol_offset;
         end
         OP_QUERY: begin
            gives = 1'b1;
            // first section holding the address wins; range test never wraps
            for (int i = 0; i < nsec && sid == 0; i++) begin
               if (it.query_address >= tbl_base[i] &&
                   it.query_address - tbl_base[i] < tbl_len[i]) begin
                  sid = i + 1;
                  offset = it.query_address - tbl_base[i];
               end
            end
            if (sid != 0) begin
               for (int i = 0; i < nsym; i++) begin
                  if (tbl_sym_sec[i] == sid && tbl_sym_val[i] <= offset) begin
                     sym_gap = offset - tbl_sym_val[i];
                     // later symbol takes equal distance
                     if (!have || sym_gap <= best_dist) begin
                        have = 1'b1;
                        best = i;
                        best_dist = sym_gap;
                     end
                  end
               end
            end
            res.found = have;
            res.section_number = SEC_FIELD_W'(sid);
            if (have) begin
               res.symbol_index = ENTRY_IDX_W'(best);
               res.symbol_value = tbl_sym_val[best];
               res.distance = best_dist;
            end
         end
         default: ;
      endcase
      return gives;
   endfunction

   function automatic lookup_req_type base_item(input logic [OPCODE_W-1:0] op,
                                                input int idx);
      lookup_req_type it;
      it.opcode = op;
      it.entry_index = ENTRY_IDX_W'(idx);
      it.section_base = $urandom;
      it.section_length = $urandom;
      it.symbol_section = SEC_FIELD_W'($urandom_range(0, MAX_SECTIONS));
      it.symbol_offset = $urandom;
      it.query_address = $urandom;
      return it;
   endfunction

   // Largest offset worth aiming at inside a section of length l
   function automatic logic [WORD_W-1:0] window(input logic [WORD_W-1:0] l);
      if (l == 0)
         return '0;
      return (l - 1 > 32'hFFFF) ? 32'hFFFF : l - 1;
   endfunction

   task automatic push_item(input lookup_req_type it);
      pending_reqs.push_back(it);
      queued_count++;
   endtask

   task automatic push_section_at(input int idx, input logic [WORD_W-1:0] b,
                                  input logic [WORD_W-1:0] l);
      lookup_req_type it;
      it = base_item(OP_LOAD_SECTION, idx);
      it.section_base = b;
      it.section_length = l;
      if (idx < MAX_SECTIONS) begin
         plan_base[idx] = b;
         plan_len[idx] = l;
         plan_sec_loaded[idx] = 1'b1;
      end
      push_item(it);
   endtask

   task automatic push_symbol_at(input int idx, input int sec, input logic [WORD_W-1:0] v);
      lookup_req_type it;
      it = base_item(OP_LOAD_SYMBOL, idx);
      it.symbol_section = SEC_FIELD_W'(sec);
      it.symbol_offset = v;
      plan_sym_sec[idx] = SEC_FIELD_W'(sec);
      plan_sym_val[idx] = v;
      plan_sym_loaded[idx] = 1'b1;
      push_item(it);
   endtask

   task automatic push_query_at(input logic [WORD_W-1:0] a);
      lookup_req_type it;
      it = base_item(OP_QUERY, $urandom_range(0, 255));
      it.query_address = a;
      push_item(it);
   endtask

   task automatic push_section(input int idx);
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] l;
      int                j;
      j = $urandom_range(0, MAX_SECTIONS - 1);
      b = $urandom;
      l = $urandom_range(1, 32'h1_0000);
      case ($urandom_range(0, 9))
         0: l = 32'hFFFF_FFFF;
         1: l = '0;
         2: begin
            // runs past the top of the address space
            b = 32'hFFFF_FFFF - $urandom_range(0, 32'hFFF);
            l = $urandom;
         end
         3, 4: if (plan_sec_loaded[j]) b = plan_base[j] + $urandom_range(0, 32'h800);
         default: ;
      endcase
      push_section_at(idx, b, l);
   endtask

   task automatic push_symbol(input int idx, input int nsec);
      logic [WORD_W-1:0] v;
      int                s;
      int                j;
      s = (nsec > 0 && $urandom_range(0, 6) != 0) ? $urandom_range(1, nsec)
                                                   : $urandom_range(0, MAX_SECTIONS);
      j = $urandom_range(0, MAX_SYMBOLS - 1);
      v = $urandom;
      if ($urandom_range(0, 6) == 0 && plan_sym_loaded[j]) begin
         // duplicate an entry to force distance ties
         s = plan_sym_sec[j];
         v = plan_sym_val[j];
      end else if (s != 0 && plan_sec_loaded[s - 1] && $urandom_range(0, 7) != 0) begin
         v = $urandom_range(0, window(plan_len[s - 1]));
      end
      push_symbol_at(idx, s, v);
   endtask

   task automatic push_query(input int nsec);
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] l;
      int                j;
      a = $urandom;
      if (nsec > 0 && $urandom_range(0, 3) != 0) begin
         j = $urandom_range(0, nsec - 1);
         b = plan_base[j];
         l = plan_len[j];
         case ($urandom_range(0, 7))
            0: a = b + l - 1;
            1: a = b + l;
            2: a = b - 1;
            default: a = b + $urandom_range(0, window(l));
         endcase
      end
      push_query_at(a);
   endtask

   task automatic write_csr(input logic idx, input int unsigned value);
      logic [CSR_ADDR_W-1:0] a;
      a = '0;
      a[CSR_INDEX_BIT] = idx;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= a;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (idx == REG_SECTION_COUNT)
         tbl_sections = SEC_COUNT_W'(value);
      else
         tbl_symbols = SYM_COUNT_W'(value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Wait until every transfer is accepted and answered, then let loads settle
   task automatic wait_idle();
      do @(negedge clock);
      while (accepted_count != queued_count || lookup_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_counts(input int sc, input int yc);
      wait_idle();
      write_csr(REG_SECTION_COUNT, sc);
      write_csr(REG_SYMBOL_COUNT, yc);
   endtask

   task automatic run_phase(input int sc, input int yc, input int n);
      int nsec;
      int nsym;
      int made;
      int pick;
      nsec = (sc > MAX_SECTIONS) ? MAX_SECTIONS : sc;
      nsym = (yc > MAX_SYMBOLS) ? MAX_SYMBOLS : yc;
      set_counts(sc, yc);
      // fill every slot the queries will search
      for (int i = 0; i < nsec; i++)
         if (!plan_sec_loaded[i]) push_section(i);
      for (int i = 0; i < nsym; i++)
         if (!plan_sym_loaded[i]) push_symbol(i, nsec);
      made = 0;
      while (made < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            push_query(nsec);
            made++;
         end else if (pick < 68) begin
            push_section($urandom_range(0, MAX_SECTIONS - 1));
            made++;
         end else if (pick < 93) begin
            push_symbol($urandom_range(0, MAX_SYMBOLS - 1), nsec);
            made++;
         end else if (pick < 96) begin
            push_item(base_item(OP_UNUSED, $urandom_range(0, 255)));
         end else begin
            push_section_at($urandom_range(MAX_SECTIONS, 255), $urandom, $urandom);
         end
      end
   endtask

   // Request driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fired) begin
         req_fired = 1'b0;
         if (req_gap > 0) begin
            req_if.valid <= 1'b0;
            req_gap--;
         end else if (pending_reqs.size() != 0) begin
            cur_req = pending_reqs.pop_front();
            req_if.opcode <= cur_req.opcode;
            req_if.entry_index <= cur_req.entry_index;
            req_if.section_base <= cur_req.section_base;
            req_if.section_length <= cur_req.section_length;
            req_if.symbol_section <= cur_req.symbol_section;
            req_if.symbol_offset <= cur_req.symbol_offset;
            req_if.query_address <= cur_req.query_address;
            req_if.valid <= 1'b1;
            req_gap = req_no_idle ? 0 : $urandom_range(0, 8);
            if ($urandom_range(0, 39) == 0) req_no_idle = !req_no_idle;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : req_accept
      result_type want;
      if (!reset && req_if.valid && req_if.ready) begin
         req_fired = 1'b1;
         accepted_count++;
         if (resolve_lookup(cur_req, want)) lookup_expected.push_back(want);
      end
   end

   // Result ready: long hold first, then per-result stall
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold--;
      end else if (rsp_stall > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_check
      result_type got;
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.found = rsp_if.found;
         got.section_number = rsp_if.section_number;
         got.symbol_index = rsp_if.symbol_index;
         got.symbol_value = rsp_if.symbol_value;
         got.distance = rsp_if.distance;
         if (lookup_expected.size() == 0) begin
            $display("%0t: unexpected result found=%0d section=%0d index=%0d value=%h dist=%h",
                     $time, got.found, got.section_number, got.symbol_index,
                     got.symbol_value, got.distance);
            failures++;
         end else begin
            want = lookup_expected.pop_front();
            if (got.found !== want.found ||
                got.section_number !== want.section_number ||
                got.symbol_index !== want.symbol_index ||
                got.symbol_value !== want.symbol_value ||
                got.distance !== want.distance) begin
               $display("%0t: mismatch expected %0d/%0d/%0d/%h/%h actual %0d/%0d/%0d/%h/%h",
                        $time, want.found, want.section_number, want.symbol_index,
                        want.symbol_value, want.distance, got.found, got.section_number,
                        got.symbol_index, got.symbol_value, got.distance);
               failures++;
            end
         end
         results_seen++;
         if (results_seen == 30 || results_seen == 150)
            rsp_hold = LONG_HOLD;
         else
            rsp_stall = rsp_no_idle ? 0 : $urandom_range(0, 8);
         if ($urandom_range(0, 29) == 0) rsp_no_idle = !rsp_no_idle;
      end
   end

   initial begin
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_if.valid = 1'b0;
      req_if.opcode = '0;
      req_if.entry_index = '0;
      req_if.section_base = '0;
      req_if.section_length = '0;
      req_if.symbol_section = '0;
      req_if.symbol_offset = '0;
      req_if.query_address = '0;
      rsp_if.ready = 1'b0;
      cur_req = '0;
      tbl_sections = '0;
      tbl_symbols = '0;
      for (int i = 0; i < MAX_SECTIONS; i++) begin
         tbl_base[i] = '0;
         tbl_len[i] = '0;
         plan_sec_loaded[i] = 1'b0;
      end
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         tbl_sym_sec[i] = '0;
         tbl_sym_val[i] = '0;
         plan_sym_loaded[i] = 1'b0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // nothing searched yet: all-zero results
      push_query_at(32'h0000_0000);
      push_query_at(32'hFFFF_FFFF);
      push_item(base_item(OP_UNUSED, 0));
      // slots beyond the section table are dropped
      push_section_at(MAX_SECTIONS, 32'h0000_0000, 32'hFFFF_FFFF);
      push_section_at(255, 32'h0000_0000, 32'hFFFF_FFFF);
      push_section_at(0, 32'h0000_1000, 32'h0000_0100);
      push_section_at(1, 32'h0000_1080, 32'h0000_1000);
      push_section_at(2, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
      push_section_at(3, 32'h0000_0000, 32'h0000_0000);
      push_symbol_at(0, 1, 32'h0000_0000);
      push_symbol_at(1, 1, 32'h0000_0080);
      push_symbol_at(2, 1, 32'h0000_0080);
      push_symbol_at(3, 3, 32'h0000_000F);
      push_symbol_at(4, MAX_SECTIONS, 32'hFFFF_FFFF);
      push_symbol_at(5, 2, 32'h0000_0200);
      set_counts(4, 6);
      push_query_at(32'h0000_1000);
      push_query_at(32'h0000_10A0);
      push_query_at(32'h0000_1100);
      push_query_at(32'hFFFF_FFFF);
      push_query_at(32'h0000_0FFF);
      push_query_at(32'h0000_10FF);

      run_phase(2, 8, 30);
      run_phase(MAX_SECTIONS, 0, 20);
      run_phase(1, 1, 20);
      run_phase(5, 40, 60);
      run_phase(MAX_SECTIONS, MAX_SYMBOLS, 100);
      run_phase(31, 511, 50);
      run_phase(0, MAX_SYMBOLS, 15);
      run_phase($urandom_range(1, MAX_SECTIONS), $urandom_range(1, MAX_SYMBOLS), 40);
      run_phase(8, 128, 40);

      wait_idle();
      if (failures == 0)
         $display("PASS address_to_symbol_lookup");
      else
         $display("FAIL address_to_symbol_lookup");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAIL address_to_symbol_lookup");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/atsl_pkg.sv
rtl/core/atsl_channels.sv
rtl/core/atsl_ram.sv
rtl/core/atsl_sec_cell.sv
rtl/core/atsl_sym_scan.sv
rtl/core/address_to_symbol_lookup.sv
tb/sv/address_to_symbol_lookup_test.sv
